// File: rtl/core/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// shared types, codes and sizes of the vertex normal accumulator
// ----------------------------------------------------------------------------
package vna_pkg;

   // vertex store size and derived index widths
   localparam int MAX_VERTICES = 4096;
   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int VCOUNT_W     = $clog2(MAX_VERTICES + 1);

   // configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_FACE_LENGTH   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_NORMAL_LENGTH = 1'd1;
   localparam logic [31:0] MIN_FACE_RESET   = 32'd4295;
   localparam logic [15:0] MIN_NORMAL_RESET = 16'd1;

   // payload types
   typedef logic [1:0]         op_type;
   typedef logic [2:0]         status_type;
   typedef logic signed [31:0] pos_type;
   typedef logic [15:0]        corner_type;
   typedef logic signed [15:0] q15_type;

   // operation codes
   localparam op_type OP_BEGIN    = 2'd0;
   localparam op_type OP_LOAD     = 2'd1;
   localparam op_type OP_TRIANGLE = 2'd2;
   localparam op_type OP_READ     = 2'd3;

   // status codes
   localparam status_type STATUS_OK         = 3'd0;
   localparam status_type STATUS_FULL       = 3'd1;
   localparam status_type STATUS_BAD_INDEX  = 3'd2;
   localparam status_type STATUS_DEGENERATE = 3'd3;
   localparam status_type STATUS_RANGE      = 3'd4;

   localparam logic [15:0] Q15_MAX = 16'd32767;

endpackage

// File: rtl/core/vna_req_if.sv
// ----------------------------------------------------------------------------
// vna_req_if
// request channel: operation, vertex position and triangle corners
// ----------------------------------------------------------------------------
interface vna_req_if;
   logic                valid;
   logic                ready;
   vna_pkg::op_type     operation;
   vna_pkg::pos_type    pos_x;
   vna_pkg::pos_type    pos_y;
   vna_pkg::pos_type    pos_z;
   vna_pkg::corner_type corner_a;
   vna_pkg::corner_type corner_b;
   vna_pkg::corner_type corner_c;

   modport source (output valid, operation, pos_x, pos_y, pos_z,
                   corner_a, corner_b, corner_c, input ready);
   modport sink (input valid, operation, pos_x, pos_y, pos_z,
                 corner_a, corner_b, corner_c, output ready);
endinterface

// File: rtl/core/vna_rsp_if.sv
// ----------------------------------------------------------------------------
// vna_rsp_if
// response channel: normal in Q1.15 and status
// ----------------------------------------------------------------------------
interface vna_rsp_if;
   logic                valid;
   logic                ready;
   vna_pkg::q15_type    normal_x;
   vna_pkg::q15_type    normal_y;
   vna_pkg::q15_type    normal_z;
   vna_pkg::status_type status;

   modport source (output valid, normal_x, normal_y, normal_z, status, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, status, output ready);
endinterface

// File: rtl/core/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// smooth per-vertex normals of an indexed triangle mesh, one shared
// multiplier, a bit-serial square root and divider under one sequencer
// ----------------------------------------------------------------------------
//
//   channel  | side   | transfer when          | carries
//   ---------+--------+------------------------+-------------------------------
//   req      | sink   | req.valid & req.ready  | operation, position, corners
//   rsp      | source | rsp.valid & rsp.ready  | normal x/y/z, status
//   csr      | apb    | psel & penable & pwrite| min_face_length, min_normal_length
//
// begin and load go straight to the done state, as do a bad corner and a range miss.
// triangle runs 32 square root steps, 3 x 19 divide
// steps, the cross product on the shared multiplier and up to 34 normalize shifts;
// a degenerate face ends at the length check.
// read ends early on the up fallback, else runs the square root and divides.
// reset is synchronous; no clearing pass, a load zeroes the sums of its vertex.
// req.ready is high only while idle; one finished response waits in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   vna_req_if.sink                             req,
   vna_rsp_if.source                           rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [vna_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int IW    = vna_pkg::VIDX_W;
   localparam int CW    = vna_pkg::VCOUNT_W;
   localparam int CMP_W = (CW > 16) ? CW : 16;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PRD   = 4'd1;
   localparam logic [3:0] ST_CROSS = 4'd2;
   localparam logic [3:0] ST_MAG   = 4'd3;
   localparam logic [3:0] ST_SQ    = 4'd4;
   localparam logic [3:0] ST_NORM  = 4'd5;
   localparam logic [3:0] ST_SQRT  = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_SRD   = 4'd8;
   localparam logic [3:0] ST_ACC   = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   // saturating edge difference
   function automatic logic signed [31:0] sat_edge(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [32:0] d;
      d = {a[31], a} - {b[31], b};
      if (d[32] != d[31]) begin
         sat_edge = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat_edge = d[31:0];
      end
   endfunction

   // saturating 64 bit difference
   function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] d;
      d = {a[63], a} - {b[63], b};
      if (d[64] != d[63]) begin
         sat_sub64 = d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_sub64 = d[63:0];
      end
   endfunction

   // saturating sum update
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] n);
      logic [32:0] s;
      s = {a[31], a} + {{17{n[15]}}, n};
      if (s[32] != s[31]) begin
         sat_add32 = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         sat_add32 = s[31:0];
      end
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? (64'd0 - v) : v;
   endfunction

   // control registers
   logic [3:0]                  state_ff, state_in;
   logic [5:0]                  cnt_ff, cnt_in;
   logic [1:0]                  comp_ff, comp_in;
   logic                        sq_pass_ff, sq_pass_in;
   logic [CW-1:0]               vcount_ff, vcount_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 mfl_ff, mfl_in;
   logic [15:0]                 mnl_ff, mnl_in;

   // payload registers
   vna_pkg::op_type             op_ff, op_in;
   logic [IW-1:0]               idx_ff [3];
   logic [IW-1:0]               idx_in [3];
   logic signed [31:0]          p0_ff [3];
   logic signed [31:0]          p0_in [3];
   logic signed [31:0]          e1_ff [3];
   logic signed [31:0]          e1_in [3];
   logic signed [31:0]          e2_ff [3];
   logic signed [31:0]          e2_in [3];
   logic signed [65:0]          prod_ff, prod_in;
   logic signed [63:0]          hold_ff, hold_in;
   logic [63:0]                 m_ff [3];
   logic [63:0]                 m_in [3];
   logic [2:0]                  neg_ff, neg_in;
   logic [65:0]                 acc_ff, acc_in;
   logic [63:0]                 x_ff, x_in;
   logic [63:0]                 res_ff, res_in;
   logic [63:0]                 bit_ff, bit_in;
   logic [49:0]                 rem_ff, rem_in;
   logic [49:0]                 den_ff, den_in;
   logic [16:0]                 q_ff, q_in;
   logic [15:0]                 n_ff [3];
   logic [15:0]                 n_in [3];
   vna_pkg::status_type         stat_ff, stat_in;
   vna_pkg::q15_type            rsp_x_ff, rsp_x_in;
   vna_pkg::q15_type            rsp_y_ff, rsp_y_in;
   vna_pkg::q15_type            rsp_z_ff, rsp_z_in;
   vna_pkg::status_type         rsp_stat_ff, rsp_stat_in;

   // memories
   logic [95:0]                 pos_mem [vna_pkg::MAX_VERTICES];
   logic [95:0]                 sum_mem [vna_pkg::MAX_VERTICES];
   logic [95:0]                 pos_rd_ff, sum_rd_ff;
   logic [IW-1:0]               pos_raddr, sum_raddr, sum_waddr;
   logic [95:0]                 pos_wdata, sum_wdata;
   logic                        pos_we, sum_we;

   // shared multiplier
   logic signed [32:0]          mul_a, mul_b;
   logic signed [65:0]          mul_p;

   // helpers
   logic [63:0]                 mx01, mx;
   logic [CMP_W-1:0]            count_ext;
   logic                        bad_a, bad_b, bad_c, full;
   logic signed [63:0]          cross_c;
   logic [1:0]                  cross_k;
   logic [64:0]                 sq_t;
   logic [32:0]                 len;
   logic [15:0]                 q_fin;
   logic [31:0]                 sum_word;
   logic                        csr_write;
   logic [vna_pkg::CSR_INDEX_W-1:0] csr_index;

   assign mul_p = mul_a * mul_b;

   assign mx01 = (m_ff[0] > m_ff[1]) ? m_ff[0] : m_ff[1];
   assign mx   = (mx01 > m_ff[2]) ? mx01 : m_ff[2];

   assign count_ext = CMP_W'(vcount_ff);
   assign bad_a = CMP_W'(req.corner_a) >= count_ext;
   assign bad_b = CMP_W'(req.corner_b) >= count_ext;
   assign bad_c = CMP_W'(req.corner_c) >= count_ext;
   assign full  = (vcount_ff == CW'(vna_pkg::MAX_VERTICES));

   assign len     = res_ff[32:0];
   assign cross_k = cnt_ff[2:1] - 2'd1;
   assign cross_c = sat_sub64(hold_ff, prod_ff[63:0]);
   assign sq_t    = {1'b0, res_ff} + {1'b0, bit_ff};
   assign q_fin   = (q_ff > 17'(vna_pkg::Q15_MAX)) ? vna_pkg::Q15_MAX : q_ff[15:0];

   // memory addresses
   assign pos_raddr = (state_ff == ST_IDLE) ? req.corner_a[IW-1:0]
                                            : idx_ff[cnt_ff[0] ? 2'd2 : 2'd1];
   assign sum_raddr = (state_ff == ST_IDLE) ? req.corner_a[IW-1:0] : idx_ff[comp_ff];

   // handshake outputs
   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.normal_x = rsp_x_ff;
   assign rsp.normal_y = rsp_y_ff;
   assign rsp.normal_z = rsp_z_ff;
   assign rsp.status   = rsp_stat_ff;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[vna_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      case (csr_index)
         vna_pkg::REG_MIN_FACE_LENGTH:   prdata = mfl_ff;
         vna_pkg::REG_MIN_NORMAL_LENGTH: prdata = {16'd0, mnl_ff};
         default:                        prdata = 32'd0;
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      sq_pass_in   = sq_pass_ff;
      vcount_in    = vcount_ff;
      rsp_valid_in = rsp_valid_ff;
      mfl_in       = mfl_ff;
      mnl_in       = mnl_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      p0_in        = p0_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      prod_in      = mul_p;
      hold_in      = hold_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      stat_in      = stat_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_stat_in  = rsp_stat_ff;
      mul_a        = 33'sd0;
      mul_b        = 33'sd0;
      pos_we       = 1'b0;
      sum_we       = 1'b0;
      pos_wdata    = {req.pos_z, req.pos_y, req.pos_x};
      sum_wdata    = 96'd0;
      sum_waddr    = idx_ff[comp_ff];
      sum_word     = 32'd0;

      // register writes
      if (csr_write) begin
         case (csr_index)
            vna_pkg::REG_MIN_FACE_LENGTH:   mfl_in = pwdata;
            vna_pkg::REG_MIN_NORMAL_LENGTH: mnl_in = pwdata[15:0];
            default: ;
         endcase
      end

      // response drains
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // take one request
         ST_IDLE: begin
            if (req.valid) begin
               op_in     = req.operation;
               idx_in[0] = req.corner_a[IW-1:0];
               idx_in[1] = req.corner_b[IW-1:0];
               idx_in[2] = req.corner_c[IW-1:0];
               for (int i = 0; i < 3; i++) begin
                  n_in[i] = 16'd0;
               end
               stat_in  = vna_pkg::STATUS_OK;
               state_in = ST_DONE;
               case (req.operation)
                  vna_pkg::OP_BEGIN: begin
                     vcount_in = '0;
                  end
                  vna_pkg::OP_LOAD: begin
                     if (full) begin
                        stat_in = vna_pkg::STATUS_FULL;
                     end else begin
                        pos_we    = 1'b1;
                        sum_we    = 1'b1;
                        sum_waddr = vcount_ff[IW-1:0];
                        vcount_in = CW'(vcount_ff + 1'b1);
                     end
                  end
                  vna_pkg::OP_TRIANGLE: begin
                     if (bad_a || bad_b || bad_c) begin
                        stat_in = vna_pkg::STATUS_BAD_INDEX;
                     end else begin
                        state_in = ST_PRD;
                        cnt_in   = 6'd0;
                     end
                  end
                  vna_pkg::OP_READ: begin
                     if (bad_a) begin
                        stat_in = vna_pkg::STATUS_RANGE;
                     end else begin
                        state_in = ST_SRD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // corner positions and edges
         ST_PRD: begin
            cnt_in = cnt_ff + 6'd1;
            for (int i = 0; i < 3; i++) begin
               if (cnt_ff == 6'd0) begin
                  p0_in[i] = pos_rd_ff[32*i +: 32];
               end else if (cnt_ff == 6'd1) begin
                  e1_in[i] = sat_edge(pos_rd_ff[32*i +: 32], p0_ff[i]);
               end else begin
                  e2_in[i] = sat_edge(pos_rd_ff[32*i +: 32], p0_ff[i]);
               end
            end
            if (cnt_ff == 6'd2) begin
               state_in = ST_CROSS;
               cnt_in   = 6'd0;
            end
         end

         // cross product, six products on the shared multiplier
         ST_CROSS: begin
            case (cnt_ff)
               6'd0: begin mul_a = {e1_ff[1][31], e1_ff[1]}; mul_b = {e2_ff[2][31], e2_ff[2]}; end
               6'd1: begin mul_a = {e1_ff[2][31], e1_ff[2]}; mul_b = {e2_ff[1][31], e2_ff[1]}; end
               6'd2: begin mul_a = {e1_ff[2][31], e1_ff[2]}; mul_b = {e2_ff[0][31], e2_ff[0]}; end
               6'd3: begin mul_a = {e1_ff[0][31], e1_ff[0]}; mul_b = {e2_ff[2][31], e2_ff[2]}; end
               6'd4: begin mul_a = {e1_ff[0][31], e1_ff[0]}; mul_b = {e2_ff[1][31], e2_ff[1]}; end
               6'd5: begin mul_a = {e1_ff[1][31], e1_ff[1]}; mul_b = {e2_ff[0][31], e2_ff[0]}; end
               default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
            endcase
            if (cnt_ff[0]) begin
               hold_in = prod_ff[63:0];
            end else if (cnt_ff != 6'd0) begin
               m_in[cross_k]   = mag64(cross_c);
               neg_in[cross_k] = cross_c[63];
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd6) begin
               state_in = ST_MAG;
            end
         end

         // small faces get the length check
         ST_MAG: begin
            cnt_in = 6'd0;
            if (mx[63:32] == 32'd0) begin
               state_in   = ST_SQ;
               sq_pass_in = 1'b0;
            end else begin
               state_in = ST_NORM;
            end
         end

         // sum of squares, then the threshold square
         ST_SQ: begin
            if (cnt_ff < 6'd3) begin
               mul_a = {1'b0, m_ff[cnt_ff[1:0]][31:0]};
            end else if (op_ff == vna_pkg::OP_READ) begin
               mul_a = {17'd0, mnl_ff};
            end else begin
               mul_a = {1'b0, mfl_ff};
            end
            mul_b  = mul_a;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd1) begin
               acc_in = {2'd0, prod_ff[63:0]};
            end else if (cnt_ff == 6'd2 || cnt_ff == 6'd3) begin
               acc_in = acc_ff + {2'd0, prod_ff[63:0]};
            end else if (cnt_ff == 6'd4) begin
               x_in   = acc_ff[63:0];
               res_in = 64'd0;
               bit_in = 64'd1 << 62;
               cnt_in = 6'd0;
               if (op_ff == vna_pkg::OP_READ) begin
                  if (acc_ff == 66'd0 || acc_ff < {2'd0, prod_ff[63:0]}) begin
                     n_in[1]  = vna_pkg::Q15_MAX;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SQRT;
                  end
               end else if (!sq_pass_ff) begin
                  if (acc_ff <= {2'd0, prod_ff[63:0]}) begin
                     stat_in  = vna_pkg::STATUS_DEGENERATE;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_NORM;
                  end
               end else begin
                  state_in = ST_SQRT;
               end
            end
         end

         // bring the largest magnitude into [2^29, 2^30)
         ST_NORM: begin
            if (mx[63:30] != 34'd0) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] >> 1;
               end
            end else if (!mx[29]) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] << 1;
               end
            end else begin
               state_in   = ST_SQ;
               sq_pass_in = 1'b1;
               cnt_in     = 6'd0;
            end
         end

         // square root, one result bit a cycle
         ST_SQRT: begin
            if ({1'b0, x_ff} >= sq_t) begin
               x_in   = x_ff - sq_t[63:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = ST_DIV;
               cnt_in   = 6'd0;
               comp_in  = 2'd0;
            end
         end

         // rounded divide by the length, one quotient bit a cycle
         ST_DIV: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd0) begin
               rem_in = (50'(m_ff[comp_ff]) << 15) + 50'(len >> 1);
               den_in = 50'(len) << 16;
               q_in   = 17'd0;
            end else if (cnt_ff <= 6'd17) begin
               if (rem_ff >= den_ff) begin
                  rem_in = rem_ff - den_ff;
                  q_in   = {q_ff[15:0], 1'b1};
               end else begin
                  q_in = {q_ff[15:0], 1'b0};
               end
               den_in = den_ff >> 1;
            end else begin
               n_in[comp_ff] = neg_ff[comp_ff] ? 16'(16'd0 - q_fin) : q_fin;
               cnt_in        = 6'd0;
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  state_in = (op_ff == vna_pkg::OP_READ) ? ST_DONE : ST_ACC;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end

         // stored sums of the vertex to read
         ST_SRD: begin
            for (int i = 0; i < 3; i++) begin
               sum_word  = sum_rd_ff[32*i +: 32];
               m_in[i]   = mag64({{32{sum_word[31]}}, sum_word});
               neg_in[i] = sum_word[31];
            end
            state_in = ST_SQ;
            cnt_in   = 6'd0;
         end

         // read-modify-write of each corner's sums
         ST_ACC: begin
            if (cnt_ff == 6'd0) begin
               cnt_in = 6'd1;
            end else begin
               sum_we = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  sum_wdata[32*i +: 32] = sat_add32(sum_rd_ff[32*i +: 32], n_ff[i]);
               end
               cnt_in = 6'd0;
               if (comp_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end

         // hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               if (op_ff == vna_pkg::OP_READ) begin
                  rsp_x_in = n_ff[0];
                  rsp_y_in = n_ff[1];
                  rsp_z_in = n_ff[2];
               end else begin
                  rsp_x_in = 16'sd0;
                  rsp_y_in = 16'sd0;
                  rsp_z_in = 16'sd0;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 6'd0;
         comp_ff      <= 2'd0;
         sq_pass_ff   <= 1'b0;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         mfl_ff       <= vna_pkg::MIN_FACE_RESET;
         mnl_ff       <= vna_pkg::MIN_NORMAL_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         sq_pass_ff   <= sq_pass_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
         mfl_ff       <= mfl_in;
         mnl_ff       <= mnl_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      p0_ff       <= p0_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      prod_ff     <= prod_in;
      hold_ff     <= hold_in;
      m_ff        <= m_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      n_ff        <= n_in;
      stat_ff     <= stat_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // position store
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[vcount_ff[IW-1:0]] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   // normal sum store
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

endmodule

// File: rtl/core/vna_checker.sv
// ----------------------------------------------------------------------------
// vna_checker
// port level checks of the vertex normal accumulator, bound to the top level
// ----------------------------------------------------------------------------
module vna_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input vna_pkg::q15_type    rsp_normal_x,
   input vna_pkg::q15_type    rsp_normal_y,
   input vna_pkg::q15_type    rsp_normal_z,
   input vna_pkg::status_type rsp_status
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_status}))
      else $error("stalled response changed");

   // the block is busy right after a request transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken twice in a row");

   // status codes stay in the defined set
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == vna_pkg::STATUS_OK ||
                     rsp_status == vna_pkg::STATUS_FULL ||
                     rsp_status == vna_pkg::STATUS_BAD_INDEX ||
                     rsp_status == vna_pkg::STATUS_DEGENERATE ||
                     rsp_status == vna_pkg::STATUS_RANGE))
      else $error("undefined status");

   // an error response carries a zero normal
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != vna_pkg::STATUS_OK |->
         rsp_normal_x == 16'sd0 && rsp_normal_y == 16'sd0 && rsp_normal_z == 16'sd0)
      else $error("error response with nonzero normal");

   // no response right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_normal_x (rsp.normal_x),
   .rsp_normal_y (rsp.normal_y),
   .rsp_normal_z (rsp.normal_z),
   .rsp_status   (rsp.status)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the vertex normal accumulator against its own predictor of face
// normals and normalized vertex sums, with random idling on both channels,
// a long response hold-off and several threshold settings
// ----------------------------------------------------------------------------
module tb_top;

   localparam int  STORE_WORDS = 3 * vna_pkg::MAX_VERTICES;
   localparam int  CYCLE_LIMIT = 1500000;
   localparam int  DRAIN_CYCLES = 200;

   typedef struct {
      vna_pkg::op_type     op;
      vna_pkg::pos_type    x, y, z;
      vna_pkg::corner_type a, b, c;
   } mesh_op_type;

   typedef struct {
      vna_pkg::q15_type    nx, ny, nz;
      vna_pkg::status_type status;
   } normal_rsp_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [vna_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   vna_req_if req_if ();
   vna_rsp_if rsp_if ();

   vertex_normal_accumulator dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [31:0] face_min;
   logic [15:0] normal_min;
   int unsigned vert_count;
   logic [31:0] pos_mem [STORE_WORDS];
   int          sum_mem [STORE_WORDS];

   mesh_op_type    pending_ops[$];
   normal_rsp_type expected_normals[$];
   int        errors;
   int        transfers_in, transfers_out;
   int        status_seen [5];
   int        cycles;
   bit        quiet;
   int        hold_req, hold_seen, hold_left;

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // integer square root, bit by bit
   function automatic logic [63:0] root64(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] unit_q15(logic [63:0] m, logic [63:0] len);
      logic [63:0] q;
      q = (m * 64'd32768 + len / 2) / len;
      if (q > 64'd32767) q = 64'd32767;
      return q[15:0];
   endfunction

   function automatic longint sat64(logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (v < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return v[63:0];
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // face normal of one triangle, added to its three corners
   function automatic vna_pkg::status_type add_face(mesh_op_type it);
      int unsigned ix [3];
      longint p [3][3];
      longint e1 [3], e2 [3], c [3], s;
      logic signed [127:0] pa, pb;
      logic [63:0] m [3], mx, len;
      logic [129:0] sq, thr;
      int n [3];
      int w;
      ix[0] = it.a; ix[1] = it.b; ix[2] = it.c;
      for (int k = 0; k < 3; k++)
         if (ix[k] >= vert_count) return vna_pkg::STATUS_BAD_INDEX;
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            p[k][i] = $signed(pos_mem[ix[k] * 3 + i]);
      // edges saturate to Q16.16
      for (int i = 0; i < 3; i++) begin
         e1[i] = sat32(p[1][i] - p[0][i]);
         e2[i] = sat32(p[2][i] - p[0][i]);
      end
      pa = e1[1] * e2[2]; pb = e1[2] * e2[1]; c[0] = sat64(pa - pb);
      pa = e1[2] * e2[0]; pb = e1[0] * e2[2]; c[1] = sat64(pa - pb);
      pa = e1[0] * e2[1]; pb = e1[1] * e2[0]; c[2] = sat64(pa - pb);
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = c[i] < 0 ? 64'(-c[i]) : 64'(c[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return vna_pkg::STATUS_DEGENERATE;
      if (mx < 64'h1_0000_0000) begin
         sq = 130'(m[0]) * 130'(m[0]) + 130'(m[1]) * 130'(m[1]) + 130'(m[2]) * 130'(m[2]);
         thr = 130'(face_min) * 130'(face_min);
         if (sq <= thr) return vna_pkg::STATUS_DEGENERATE;
      end
      // bring the largest magnitude into [2^29, 2^30)
      while (mx >= 64'd1 << 30) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < 64'd1 << 29) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         n[i] = unit_q15(m[i], len);
         if (c[i] < 0) n[i] = -n[i];
      end
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++) begin
            w = ix[k] * 3 + i;
            s = sat32(longint'(sum_mem[w]) + n[i]);
            sum_mem[w] = int'(s);
         end
      return vna_pkg::STATUS_OK;
   endfunction

   // expected result of one accepted operation
   function automatic normal_rsp_type predict_normal(mesh_op_type it);
      normal_rsp_type r;
      logic [63:0] m [3], s, len;
      int unsigned v;
      r = '{nx: 0, ny: 0, nz: 0, status: vna_pkg::STATUS_OK};
      case (it.op)
         vna_pkg::OP_BEGIN: begin
            vert_count = 0;
            for (int w = 0; w < STORE_WORDS; w++) sum_mem[w] = 0;
         end
         vna_pkg::OP_LOAD: begin
            if (vert_count >= vna_pkg::MAX_VERTICES) begin
               r.status = vna_pkg::STATUS_FULL;
            end else begin
               pos_mem[vert_count * 3]     = it.x;
               pos_mem[vert_count * 3 + 1] = it.y;
               pos_mem[vert_count * 3 + 2] = it.z;
               vert_count++;
            end
         end
         vna_pkg::OP_TRIANGLE: r.status = add_face(it);
         default: begin
            v = it.a;
            if (v >= vert_count) begin
               r.status = vna_pkg::STATUS_RANGE;
            end else begin
               s = 0;
               for (int i = 0; i < 3; i++) begin
                  m[i] = sum_mem[v * 3 + i] < 0 ? 64'(-longint'(sum_mem[v * 3 + i]))
                                                : 64'(sum_mem[v * 3 + i]);
                  s += m[i] * m[i];
               end
               if (s == 0 || s < 64'(normal_min) * 64'(normal_min)) begin
                  r.ny = vna_pkg::Q15_MAX;
               end else begin
                  len = root64(s);
                  r.nx = unit_q15(m[0], len);
                  r.ny = unit_q15(m[1], len);
                  r.nz = unit_q15(m[2], len);
                  if (sum_mem[v * 3] < 0)     r.nx = -r.nx;
                  if (sum_mem[v * 3 + 1] < 0) r.ny = -r.ny;
                  if (sum_mem[v * 3 + 2] < 0) r.nz = -r.nz;
               end
            end
         end
      endcase
      return r;
   endfunction

   // request driver with random idle bursts
   mesh_op_type cur_op;
   int          send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
         req_if.operation <= vna_pkg::OP_BEGIN;
         req_if.pos_x <= 0; req_if.pos_y <= 0; req_if.pos_z <= 0;
         req_if.corner_a <= 0; req_if.corner_b <= 0; req_if.corner_c <= 0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_normals.insert(expected_normals.size(), predict_normal(cur_op));
            transfers_in++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(1, 7) - 1;
               req_if.valid <= 0;
            end else if (pending_ops.size() > 0) begin
               cur_op = pending_ops.pop_front();
               req_if.operation <= cur_op.op;
               req_if.pos_x <= cur_op.x;
               req_if.pos_y <= cur_op.y;
               req_if.pos_z <= cur_op.z;
               req_if.corner_a <= cur_op.a;
               req_if.corner_b <= cur_op.b;
               req_if.corner_c <= cur_op.c;
               req_if.valid <= 1;
            end else begin
               req_if.valid <= 0;
            end
         end
      end
   end

   task automatic report(string field, int got, int want);
      $display("mismatch on %s at response %0d: got %0d, expected %0d",
               field, transfers_out, got, want);
      errors++;
   endtask

   // long response hold-off, counted down on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = 400;
      end else if (hold_left > 0) begin
         hold_left--;
      end
   end

   // response monitor and random stalls
   int             stall;
   normal_rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
         stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_normals.size() == 0) begin
               $display("response %0d arrived with nothing expected", transfers_out);
               errors++;
            end else begin
               want = expected_normals.pop_front();
               if (rsp_if.status != want.status) report("status", rsp_if.status, want.status);
               if (rsp_if.normal_x != want.nx) report("normal_x", rsp_if.normal_x, want.nx);
               if (rsp_if.normal_y != want.ny) report("normal_y", rsp_if.normal_y, want.ny);
               if (rsp_if.normal_z != want.nz) report("normal_z", rsp_if.normal_z, want.nz);
               if (want.status <= vna_pkg::STATUS_RANGE) status_seen[want.status]++;
            end
            transfers_out++;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 0;
         end else if (stall > 0) begin
            stall--;
            rsp_if.ready <= 0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            rsp_if.ready <= 0;
         end else begin
            rsp_if.ready <= 1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("vertex_normal_accumulator test failed");
         $finish;
      end
   end

   // apb write: setup then access
   task automatic csr_write(logic [vna_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (idx == vna_pkg::REG_MIN_FACE_LENGTH) face_min = value;
      else normal_min = value[15:0];
   endtask

   // wait until nothing is queued, offered or outstanding
   task automatic wait_idle();
      bit busy;
      busy = 1;
      while (busy) begin
         while (pending_ops.size() > 0 || req_if.valid || expected_normals.size() > 0)
            @(posedge clock);
         repeat (4) @(posedge clock);
         busy = pending_ops.size() > 0 || req_if.valid || expected_normals.size() > 0;
      end
   endtask

   function automatic mesh_op_type make_op(vna_pkg::op_type op, int x, int y, int z,
                                           int a, int b, int c);
      mesh_op_type it;
      it.op = op; it.x = x; it.y = y; it.z = z;
      it.a = 16'(a); it.b = 16'(b); it.c = 16'(c);
      return it;
   endfunction

   task automatic add_op(mesh_op_type it);
      pending_ops.insert(pending_ops.size(), it);
   endtask

   // mostly small coordinates, sometimes the full range
   function automatic vna_pkg::pos_type rand_pos(bit wide);
      if (wide || $urandom_range(0, 4) == 0) return $urandom;
      return int'($urandom_range(0, 2097152)) - 1048576;
   endfunction

   // random meshes: begin, a few loads, then triangles and reads, plus noise
   task automatic queue_meshes(int count, bit wide);
      int nv, k;
      vna_pkg::pos_type px, py, pz;
      while (count > 0) begin
         add_op(make_op(vna_pkg::OP_BEGIN, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom));
         nv = $urandom_range(3, 12);
         for (int i = 0; i < nv; i++) begin
            if (i == 0 || $urandom_range(0, 5) != 0) begin
               px = rand_pos(wide); py = rand_pos(wide); pz = rand_pos(wide);
            end
            add_op(make_op(vna_pkg::OP_LOAD, px, py, pz, $urandom, $urandom, $urandom));
         end
         k = $urandom_range(4, 20);
         for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 9))
               0: add_op(make_op(vna_pkg::op_type'($urandom_range(0, 3)), $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom));
               1, 2, 3: add_op(make_op(vna_pkg::OP_READ, $urandom, $urandom, $urandom,
                     $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                               : $urandom_range(0, nv),
                     $urandom, $urandom));
               default: add_op(make_op(vna_pkg::OP_TRIANGLE, $urandom, $urandom,
                     $urandom, $urandom_range(0, nv - 1), $urandom_range(0, nv - 1),
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                               : $urandom_range(0, nv - 1)));
            endcase
         end
         count -= 1 + nv + k;
      end
   endtask

   // stimulus sequence
   initial begin
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      errors = 0;
      face_min = vna_pkg::MIN_FACE_RESET;
      normal_min = vna_pkg::MIN_NORMAL_RESET;
      vert_count = 0;
      for (int w = 0; w < STORE_WORDS; w++) begin
         sum_mem[w] = 0;
         pos_mem[w] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: extremes, every operation and every status but full
      csr_write(vna_pkg::REG_MIN_FACE_LENGTH, vna_pkg::MIN_FACE_RESET);
      csr_write(vna_pkg::REG_MIN_NORMAL_LENGTH, 32'(vna_pkg::MIN_NORMAL_RESET));
      add_op(make_op(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 0, 0));
      add_op(make_op(vna_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0));
      add_op(make_op(vna_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0));
      add_op(make_op(vna_pkg::OP_LOAD, 65536, 0, 0, 0, 0, 0));
      add_op(make_op(vna_pkg::OP_LOAD, 0, 65536, 0, 0, 0, 0));
      add_op(make_op(vna_pkg::OP_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     65535, 65535, 65535));
      add_op(make_op(vna_pkg::OP_LOAD, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                     0, 0, 0));
      add_op(make_op(vna_pkg::OP_LOAD, 1, 0, 0, 0, 0, 0));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 1, 2));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 2, 1, 0));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 0, 1));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 3, 4));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 1, 5));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 0, 5, 1));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 65535, 0, 1));
      add_op(make_op(vna_pkg::OP_TRIANGLE, 0, 0, 0, 5, 0, 1));
      add_op(make_op(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
      add_op(make_op(vna_pkg::OP_READ, 0, 0, 0, 1, 0, 0));
      add_op(make_op(vna_pkg::OP_READ, 0, 0, 0, 3, 0, 0));
      add_op(make_op(vna_pkg::OP_READ, 0, 0, 0, 5, 0, 0));
      add_op(make_op(vna_pkg::OP_READ, 0, 0, 0, 6, 0, 0));
      add_op(make_op(vna_pkg::OP_READ, 0, 0, 0, 65535, 0, 0));
      wait_idle();

      // reset thresholds, with a long response hold-off while the sender keeps going
      queue_meshes(240, 0);
      repeat (50) @(posedge clock);
      hold_req++;
      wait_idle();

      // lowest thresholds
      csr_write(vna_pkg::REG_MIN_FACE_LENGTH, 32'd0);
      csr_write(vna_pkg::REG_MIN_NORMAL_LENGTH, 32'd0);
      queue_meshes(140, 0);
      wait_idle();

      // highest thresholds, wide coordinates so that some faces still count
      csr_write(vna_pkg::REG_MIN_FACE_LENGTH, 32'hFFFFFFFF);
      csr_write(vna_pkg::REG_MIN_NORMAL_LENGTH, 32'd65535);
      queue_meshes(100, 1);
      wait_idle();

      // random thresholds
      csr_write(vna_pkg::REG_MIN_FACE_LENGTH, $urandom_range(0, 1 << 20));
      csr_write(vna_pkg::REG_MIN_NORMAL_LENGTH, $urandom_range(0, 40000));
      queue_meshes(140, 0);
      wait_idle();

      // last part, no idling on either side
      quiet = 1;
      csr_write(vna_pkg::REG_MIN_FACE_LENGTH, vna_pkg::MIN_FACE_RESET);
      csr_write(vna_pkg::REG_MIN_NORMAL_LENGTH, 32'(vna_pkg::MIN_NORMAL_RESET));
      queue_meshes(160, 0);

      // drain and finish
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests and %0d responses over five threshold settings",
               transfers_in, transfers_out);
      $display("status counts ok %0d full %0d bad index %0d degenerate %0d range %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (errors == 0 && expected_normals.size() == 0) begin
         $display("vertex_normal_accumulator test passed");
      end else begin
         $display("vertex_normal_accumulator test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/vna_pkg.sv
rtl/core/vna_req_if.sv
rtl/core/vna_rsp_if.sv
rtl/core/vertex_normal_accumulator.sv
rtl/core/vna_checker.sv
dv/tb_top.sv
